/* rtl/lfbd_pkg.sv */
// Shared types and constants for the LZSS flag-byte decompressor.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`default_nettype none

package lfbd_pkg;

    // Field widths of the byte stream
    localparam int BYTE_W     = 8;
    localparam int OFFSET_W   = 12;
    localparam int LEN_CODE_W = 4;
    localparam int FLAG_CNT_W = 3;
    // Copy length is code + COPY_BIAS, at most 17, so it needs five bits
    localparam int COPY_CNT_W = 5;
    localparam int COPY_BIAS  = 2;

    // Default history size
    localparam int HISTORY_DEPTH_DEF = 4096;

    // Stream parse position
    typedef enum logic [1:0] {
        PH_CONTROL  = 2'd0,
        PH_ITEM     = 2'd1,
        PH_CODE_LOW = 2'd2,
        PH_ENDED    = 2'd3
    } phase_t;

    // Output sequencer
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_PUT
    } seq_state_t;

    // What the sequencer emits in S_PUT
    typedef enum logic [1:0] {
        PUT_LIT,
        PUT_COPY,
        PUT_END
    } put_kind_t;

endpackage

`default_nettype wire

/* rtl/lfbd_in_if.sv */
// Request channel carrying compressed bytes into the decompressor.
// Depends on lfbd_pkg for the byte width.
`default_nettype none

interface lfbd_in_if;
    logic                        valid;
    logic                        ready;
    logic [lfbd_pkg::BYTE_W-1:0] in_byte;
    logic                        start_frame;

    modport source (output valid, output in_byte, output start_frame, input ready);
    modport sink   (input valid, input in_byte, input start_frame, output ready);
endinterface

`default_nettype wire

/* rtl/lfbd_out_if.sv */
// Request channel carrying decompressed bytes out of the decompressor.
// Depends on lfbd_pkg for the byte width.
`default_nettype none

interface lfbd_out_if;
    logic                        valid;
    logic                        ready;
    logic [lfbd_pkg::BYTE_W-1:0] out_byte;
    logic                        last_of_run;
    logic                        end_of_stream;

    modport source (output valid, output out_byte, output last_of_run,
                    output end_of_stream, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input end_of_stream, output ready);
endinterface

`default_nettype wire

/* rtl/lzss_flag_byte_decompressor_unit.sv */
// Top level of the LZSS flag-byte decompressor: parser, copy sequencer, history RAM.
// Depends on lfbd_pkg, lfbd_in_if and lfbd_out_if.
//
//  channel | direction | payload                                  | handshake
//  --------+-----------+------------------------------------------+-----------
//  code    | sink      | in_byte[7:0], start_frame                | valid/ready
//  data    | source    | out_byte[7:0], last_of_run, end_of_stream | valid/ready
//
// Control and first codeword bytes finish in S_IDLE; a literal or end codeword then
// passes through S_PUT. Each byte of a copy is a history RAM read in S_READ followed
// by a write in S_PUT, both through the single RAM port, with the source address from
// one shared subtract-and-wrap unit. A full output register not taken holds S_PUT.
// Reset and start_frame clear the history logically through a fill count, so there
// is no clearing pass; entries not written since the frame start read as zero.
`default_nettype none

module lzss_flag_byte_decompressor_unit #(
    parameter int HISTORY_DEPTH = lfbd_pkg::HISTORY_DEPTH_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    lfbd_in_if.sink      code,
    lfbd_out_if.source   data
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [AW-1:0] WP_LAST   = AW'(HISTORY_DEPTH - 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(HISTORY_DEPTH);
    localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(HISTORY_DEPTH);

    localparam int BW = lfbd_pkg::BYTE_W;
    localparam int OW = lfbd_pkg::OFFSET_W;
    localparam int CW = lfbd_pkg::COPY_CNT_W;
    localparam int UW = lfbd_pkg::FLAG_CNT_W;
    localparam int LW = lfbd_pkg::LEN_CODE_W;

    // History RAM
    logic [BW-1:0] hist_mem [HISTORY_DEPTH];
    logic [BW-1:0] rdata_reg;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] src_addr;

    // Control state
    lfbd_pkg::seq_state_t state_reg,  state_next;
    lfbd_pkg::phase_t     phase_reg,  phase_next;
    lfbd_pkg::put_kind_t  kind_reg,   kind_next;
    logic [BW-1:0]        flag_reg,   flag_next;
    logic [UW-1:0]        used_reg,   used_next;
    logic [BW-1:0]        cw_high_reg, cw_high_next;
    logic [AW-1:0]        wp_reg,     wp_next;
    logic [FW-1:0]        fill_reg,   fill_next;
    logic [OW-1:0]        dist_reg,   dist_next;
    logic [CW-1:0]        left_reg,   left_next;
    logic                 hit_reg,    hit_next;
    logic                 out_valid_reg, out_valid_next;

    // Payload registers
    logic [BW-1:0] lit_reg,  lit_next;
    logic [BW-1:0] obyte_reg, obyte_next;
    logic          olast_reg, olast_next;
    logic          oend_reg,  oend_next;

    logic               in_fire;
    logic               put_go;
    logic [BW-1:0]      put_byte;
    logic [OW-1:0]      offset;
    logic [AW:0]        diff;
    lfbd_pkg::phase_t   ph_eff;
    logic [UW-1:0]      used_inc;

    assign code.ready     = (state_reg == lfbd_pkg::S_IDLE);
    assign in_fire        = code.valid && code.ready;
    assign data.valid     = out_valid_reg;
    assign data.out_byte  = obyte_reg;
    assign data.last_of_run   = olast_reg;
    assign data.end_of_stream = oend_reg;

    // Shared address unit: source = write position minus distance, modulo depth
    assign diff     = {1'b0, wp_reg} - (AW + 1)'(dist_reg);
    assign src_addr = diff[AW] ? AW'(diff + DEPTH_EXT) : diff[AW-1:0];

    assign offset   = {cw_high_reg, code.in_byte[BW-1:LW]};
    assign used_inc = used_reg + 1'b1;
    assign put_go   = (state_reg == lfbd_pkg::S_PUT) && (!out_valid_reg || data.ready);
    assign put_byte = (kind_reg == lfbd_pkg::PUT_LIT) ? lit_reg :
                      (hit_reg ? rdata_reg : '0);

    // Parser and copy sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        flag_next      = flag_reg;
        used_next      = used_reg;
        cw_high_next   = cw_high_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        dist_next      = dist_reg;
        left_next      = left_reg;
        hit_next       = hit_reg;
        lit_next       = lit_reg;
        obyte_next     = obyte_reg;
        olast_next     = olast_reg;
        oend_next      = oend_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        ph_eff         = code.start_frame ? lfbd_pkg::PH_CONTROL : phase_reg;

        // output register drains
        if (data.valid && data.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            lfbd_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    if (code.start_frame)
                    begin
                        wp_next   = '0;
                        fill_next = '0;
                    end
                    unique case (ph_eff)
                        lfbd_pkg::PH_CONTROL:
                        begin
                            flag_next  = code.in_byte;
                            used_next  = '0;
                            phase_next = lfbd_pkg::PH_ITEM;
                        end
                        lfbd_pkg::PH_ITEM:
                        begin
                            if (flag_reg[BW-1])
                            begin
                                cw_high_next = code.in_byte;
                                phase_next   = lfbd_pkg::PH_CODE_LOW;
                            end
                            else
                            begin
                                lit_next   = code.in_byte;
                                kind_next  = lfbd_pkg::PUT_LIT;
                                state_next = lfbd_pkg::S_PUT;
                                flag_next  = {flag_reg[BW-2:0], 1'b0};
                                used_next  = used_inc;
                                phase_next = (used_inc == '0) ? lfbd_pkg::PH_CONTROL
                                                              : lfbd_pkg::PH_ITEM;
                            end
                        end
                        lfbd_pkg::PH_CODE_LOW:
                        begin
                            if (offset == '0)
                            begin
                                kind_next  = lfbd_pkg::PUT_END;
                                state_next = lfbd_pkg::S_PUT;
                                phase_next = lfbd_pkg::PH_ENDED;
                            end
                            else
                            begin
                                dist_next  = offset;
                                left_next  = CW'(code.in_byte[LW-1:0]) +
                                             CW'(lfbd_pkg::COPY_BIAS);
                                kind_next  = lfbd_pkg::PUT_COPY;
                                state_next = lfbd_pkg::S_READ;
                                flag_next  = {flag_reg[BW-2:0], 1'b0};
                                used_next  = used_inc;
                                phase_next = (used_inc == '0) ? lfbd_pkg::PH_CONTROL
                                                              : lfbd_pkg::PH_ITEM;
                            end
                        end
                        lfbd_pkg::PH_ENDED:
                        begin
                            phase_next = lfbd_pkg::PH_ENDED;
                        end
                        default:
                        begin
                            phase_next = lfbd_pkg::PH_CONTROL;
                        end
                    endcase
                end
            end

            lfbd_pkg::S_READ:
            begin
                // entry is live only if written since the frame start
                mem_re     = 1'b1;
                hit_next   = (FW'(dist_reg) <= fill_reg);
                state_next = lfbd_pkg::S_PUT;
            end

            lfbd_pkg::S_PUT:
            begin
                if (put_go)
                begin
                    out_valid_next = 1'b1;
                    if (kind_reg == lfbd_pkg::PUT_END)
                    begin
                        obyte_next = '0;
                        olast_next = 1'b1;
                        oend_next  = 1'b1;
                        state_next = lfbd_pkg::S_IDLE;
                    end
                    else
                    begin
                        obyte_next = put_byte;
                        oend_next  = 1'b0;
                        mem_we     = 1'b1;
                        wp_next    = (wp_reg == WP_LAST) ? '0 : wp_reg + 1'b1;
                        fill_next  = (fill_reg == FILL_FULL) ? fill_reg : fill_reg + 1'b1;
                        if (kind_reg == lfbd_pkg::PUT_LIT)
                        begin
                            olast_next = 1'b1;
                            state_next = lfbd_pkg::S_IDLE;
                        end
                        else
                        begin
                            olast_next = (left_reg == CW'(1));
                            left_next  = left_reg - 1'b1;
                            state_next = (left_reg == CW'(1)) ? lfbd_pkg::S_IDLE
                                                              : lfbd_pkg::S_READ;
                        end
                    end
                end
            end

            default:
            begin
                state_next = lfbd_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfbd_pkg::S_IDLE;
            phase_reg     <= lfbd_pkg::PH_CONTROL;
            kind_reg      <= lfbd_pkg::PUT_LIT;
            flag_reg      <= '0;
            used_reg      <= '0;
            cw_high_reg   <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            dist_reg      <= '0;
            left_reg      <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            flag_reg      <= flag_next;
            used_reg      <= used_next;
            cw_high_reg   <= cw_high_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            dist_reg      <= dist_next;
            left_reg      <= left_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lit_reg   <= lit_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
        oend_reg  <= oend_next;
    end

    // History RAM: one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[wp_reg] <= put_byte;
        end
        else if (mem_re)
        begin
            rdata_reg <= hist_mem[src_addr];
        end
    end

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("fill count above history depth");

    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= WP_LAST)
        else $error("write position out of range");

    a_read_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lfbd_pkg::S_READ) |-> (left_reg != '0))
        else $error("copy read with no bytes left");

    a_out_from_put: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg ##1 out_valid_reg) |-> $past(state_reg == lfbd_pkg::S_PUT))
        else $error("result loaded outside the put step");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (data.valid && data.end_of_stream) |-> data.last_of_run)
        else $error("end result not marked last");

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for lzss_flag_byte_decompressor_unit: drives compressed bytes,
// predicts every decompressed byte with an internal decoder and checks the output channel.
// Depends on lfbd_pkg, lfbd_in_if, lfbd_out_if and the unit under test.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_DEPTH = lfbd_pkg::HISTORY_DEPTH_DEF;
    localparam int ITEMS      = 330;
    localparam int MAX_SHOWN  = 10;

    // One decompressed byte as it should appear on the output channel
    typedef struct packed {
        logic [lfbd_pkg::BYTE_W-1:0] data;
        logic                        last;
        logic                        eos;
    } out_rec_t;

    // Decoder state mirror plus the queue of bytes still owed by the unit
    class decode_board;
        lfbd_pkg::phase_t                  ph;
        logic [lfbd_pkg::BYTE_W-1:0]       flags;
        logic [lfbd_pkg::FLAG_CNT_W-1:0]   flags_done;
        logic [lfbd_pkg::BYTE_W-1:0]       code_hi;
        logic [lfbd_pkg::BYTE_W-1:0]       hist [HIST_DEPTH];
        logic [lfbd_pkg::OFFSET_W-1:0]     wpos;
        out_rec_t                          pending_bytes [$];
        int                                errors;

        function new();
            errors     = 0;
            ph         = lfbd_pkg::PH_CONTROL;
            flags      = '0;
            flags_done = '0;
            code_hi    = '0;
            clear_frame();
        endfunction

        function void clear_frame();
            foreach (hist[i]) hist[i] = '0;
            wpos = '0;
        endfunction

        function void flag_error(string msg);
            errors++;
            if (errors <= MAX_SHOWN)
                $display("%0t: %s", $time, msg);
        endfunction

        function void emit(logic [lfbd_pkg::BYTE_W-1:0] b, logic last, logic eos);
            out_rec_t r;
            r.data = b;
            r.last = last;
            r.eos  = eos;
            pending_bytes.push_back(r);
        endfunction

        function void keep(logic [lfbd_pkg::BYTE_W-1:0] b);
            hist[wpos] = b;
            wpos       = wpos + 1'b1;
        endfunction

        function void next_flag();
            flags      = flags << 1;
            flags_done = flags_done + 1'b1;
            ph         = (flags_done == 0) ? lfbd_pkg::PH_CONTROL : lfbd_pkg::PH_ITEM;
        endfunction

        // Accepted request; returns 0 when the byte is dropped after end of stream
        function bit take_code_byte(logic [lfbd_pkg::BYTE_W-1:0] b, logic s);
            logic [15:0]                   cw;
            logic [lfbd_pkg::OFFSET_W-1:0] off;
            int                            count;
            logic [lfbd_pkg::BYTE_W-1:0]   v;
            if (s)
            begin
                clear_frame();
                ph = lfbd_pkg::PH_CONTROL;
            end
            case (ph)
                lfbd_pkg::PH_CONTROL:
                begin
                    flags      = b;
                    flags_done = '0;
                    ph         = lfbd_pkg::PH_ITEM;
                end
                lfbd_pkg::PH_ITEM:
                begin
                    if (flags[7])
                    begin
                        code_hi = b;
                        ph      = lfbd_pkg::PH_CODE_LOW;
                    end
                    else
                    begin
                        emit(b, 1'b1, 1'b0);
                        keep(b);
                        next_flag();
                    end
                end
                lfbd_pkg::PH_CODE_LOW:
                begin
                    cw    = {code_hi, b};
                    off   = cw[15:4];
                    count = cw[3:0] + lfbd_pkg::COPY_BIAS;
                    if (off == 0)
                    begin
                        emit('0, 1'b1, 1'b1);
                        ph = lfbd_pkg::PH_ENDED;
                    end
                    else
                    begin
                        // byte-by-byte copy, so overlapping sources repeat fresh bytes
                        for (int i = 0; i < count; i++)
                        begin
                            v = hist[lfbd_pkg::OFFSET_W'(wpos - off)];
                            emit(v, i == count - 1, 1'b0);
                            keep(v);
                        end
                        next_flag();
                    end
                end
                default:
                    return 1'b0;
            endcase
            return 1'b1;
        endfunction

        // End marker carries a zero byte
        function void match_output(logic [lfbd_pkg::BYTE_W-1:0] b, logic last, logic eos);
            out_rec_t want;
            if (pending_bytes.size() == 0)
            begin
                flag_error($sformatf("unexpected output: byte %02h last %0b end %0b",
                                     b, last, eos));
                return;
            end
            want = pending_bytes.pop_front();
            if (want.last !== last || want.eos !== eos || want.data !== b)
                flag_error($sformatf({"output mismatch: expected byte %02h last %0b end %0b,",
                                      " got byte %02h last %0b end %0b"},
                                     want.data, want.last, want.eos, b, last, eos));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    lfbd_in_if  code_if ();
    lfbd_out_if data_if ();

    lzss_flag_byte_decompressor_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .code  (code_if),
        .data  (data_if)
    );

    decode_board board = new();
    int          send_idle = 0;
    int          recv_stall = 0;
    int          decoded = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #1000000;
        $display("tb_top: done, errors");
        $finish;
    end

    // Output side: check each accepted byte, then pick the next ready
    initial
    begin
        data_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && data_if.valid === 1'b1 && data_if.ready === 1'b1)
                board.match_output(data_if.out_byte, data_if.last_of_run,
                                   data_if.end_of_stream);
            data_if.ready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
        end
    end

    // One request on the input channel, with random idle cycles ahead of it
    task automatic push_code(input logic [lfbd_pkg::BYTE_W-1:0] b, input logic s);
        while (send_idle != 0 && $urandom_range(99) < send_idle)
        begin
            code_if.valid <= 1'b0;
            @(posedge clk);
        end
        code_if.valid       <= 1'b1;
        code_if.in_byte     <= b;
        code_if.start_frame <= s;
        @(posedge clk);
        while (code_if.ready !== 1'b1) @(posedge clk);
        if (board.take_code_byte(b, s))
            decoded++;
    endtask

    // Hold off the sender until the unit has delivered everything owed
    task automatic drain();
        code_if.valid <= 1'b0;
        do @(posedge clk); while (board.pending_bytes.size() != 0);
    endtask

    // Mostly well-formed frame with random content; may end, break off or run out
    task automatic send_frame();
        int                          groups;
        int                          produced;
        int                          r;
        int                          off;
        int                          len;
        logic [lfbd_pkg::BYTE_W-1:0] ctl;
        groups   = $urandom_range(1, 6);
        produced = 0;
        ctl      = lfbd_pkg::BYTE_W'($urandom_range(255));
        push_code(ctl, 1'b1);
        for (int g = 0; g < groups; g++)
        begin
            if (g != 0)
            begin
                ctl = lfbd_pkg::BYTE_W'($urandom_range(255));
                push_code(ctl, 1'b0);
            end
            for (int f = 7; f >= 0; f--)
            begin
                if (!ctl[f])
                begin
                    push_code(lfbd_pkg::BYTE_W'($urandom_range(255)), 1'b0);
                    produced++;
                    continue;
                end
                r = $urandom_range(99);
                // end codeword, then up to three bytes the unit must drop
                if (r < 4)
                begin
                    push_code(8'h00, 1'b0);
                    push_code({4'h0, 4'($urandom_range(15))}, 1'b0);
                    repeat ($urandom_range(3))
                        push_code(lfbd_pkg::BYTE_W'($urandom_range(255)), 1'b0);
                    return;
                end
                // abandon the frame halfway through a codeword
                if (r < 7)
                begin
                    push_code(lfbd_pkg::BYTE_W'($urandom_range(255)), 1'b0);
                    return;
                end
                // abandon the frame with flags still pending
                if (r < 10)
                    return;
                r = $urandom_range(99);
                if (produced == 0 || r < 8)
                    off = $urandom_range(1, 4095);
                else if (r < 12)
                    off = 4095;
                else
                    off = $urandom_range(1, (produced < 64) ? produced : 64);
                len = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(3);
                push_code(off[11:4], 1'b0);
                push_code({off[3:0], len[3:0]}, 1'b0);
                produced += len + lfbd_pkg::COPY_BIAS;
            end
        end
    endtask

    // Stimulus
    initial
    begin
        int mode;
        int want_mode;
        rst_n               = 1'b0;
        code_if.valid       = 1'b0;
        code_if.in_byte     = '0;
        code_if.start_frame = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first control byte without start_frame
        push_code(8'h60, 1'b0);
        push_code(8'hFF, 1'b0);
        // offset 1, longest length: overlapping copy of one byte
        push_code(8'h00, 1'b0);
        push_code(8'h1F, 1'b0);
        // largest offset reaches behind the first output byte
        push_code(8'hFF, 1'b0);
        push_code(8'hF0, 1'b0);
        push_code(8'h00, 1'b0);
        push_code(8'h80, 1'b0);
        push_code(8'h01, 1'b0);
        push_code(8'h7F, 1'b0);
        push_code(8'h55, 1'b0);
        // new frame: copy from cleared history
        push_code(8'hC0, 1'b1);
        push_code(8'h00, 1'b0);
        push_code(8'h31, 1'b0);
        // restart while a codeword is half received
        push_code(8'h12, 1'b0);
        push_code(8'h80, 1'b1);
        // end codeword, then bytes that are dropped
        push_code(8'h00, 1'b0);
        push_code(8'h07, 1'b0);
        push_code(8'hFF, 1'b0);
        push_code(8'h00, 1'b0);
        // restart after the end
        push_code(8'h00, 1'b1);
        push_code(8'hAB, 1'b0);
        drain();

        // Random frames, with idle phases switched at frame boundaries
        mode = 0;
        while (decoded < ITEMS)
        begin
            want_mode = (decoded * 4) / ITEMS;
            if (want_mode > 3)
                want_mode = 3;
            if (want_mode != mode)
            begin
                drain();
                mode = want_mode;
                case (mode)
                    1:
                    begin
                        send_idle  = 63;
                        recv_stall = 0;
                    end
                    2:
                    begin
                        send_idle  = 0;
                        recv_stall = 63;
                    end
                    default:
                    begin
                        send_idle  = 14;
                        recv_stall = 14;
                    end
                endcase
            end
            if ($urandom_range(9) == 0)
            begin
                // noise: arbitrary bytes and restarts
                repeat ($urandom_range(1, 6))
                    push_code(lfbd_pkg::BYTE_W'($urandom_range(255)), $urandom_range(3) == 0);
            end
            else
            begin
                send_frame();
            end
        end

        // Wait out the remaining output plus the longest copy
        code_if.valid <= 1'b0;
        do @(posedge clk); while (board.pending_bytes.size() != 0);
        repeat (100) @(posedge clk);
        if (board.errors == 0 && board.pending_bytes.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule

/* files.f */
rtl/lfbd_pkg.sv
rtl/lfbd_in_if.sv
rtl/lfbd_out_if.sv
rtl/lzss_flag_byte_decompressor_unit.sv
test/tb_top.sv
